### rtl/lssc_pkg.sv
// Package with shared types and constants for the load/store subset CPU step block.
package lssc_pkg;

    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2b;

    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_SUB = 6'h22;
    localparam logic [5:0] FN_AND = 6'h24;
    localparam logic [5:0] FN_OR  = 6'h25;

    localparam logic [31:0] PC_STEP      = 32'h4;
    localparam logic [31:0] PC_HIGH_MASK = 32'hF0000000;
    localparam logic [31:0] PC_LOW_MASK  = 32'h0FFFFFFF;

    typedef enum logic [3:0] {
        K_ALU   = 4'b0001,
        K_MEM   = 4'b0010,
        K_PC    = 4'b0100,
        K_BAD   = 4'b1000
    } kind_t;

    typedef enum logic [3:0] {
        U_ADD = 4'b0001,
        U_SUB = 4'b0010,
        U_AND = 4'b0100,
        U_OR  = 4'b1000
    } alu_op_t;

    // Classified item passed from the front to the back.
    typedef struct packed {
        kind_t       kind;
        alu_op_t     alu_op;
        logic        is_exec;
        logic        is_write;
        logic        is_read;
        logic        is_load;
        logic        is_store;
        logic        is_beq;
        logic        is_jump;
        logic        target_store;
        logic [9:0]  word_index;
        logic [31:0] write_value;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [31:0] simm;
        logic [25:0] target;
    } op_t;

endpackage

### rtl/lssc_front.sv
// Front end: accepts items, decodes them and queues them for the back end.
module lssc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        action,
    input  logic [31:0]       instruction,
    input  logic              target_store,
    input  logic [9:0]        word_index,
    input  logic [31:0]       write_value,
    output logic              op_valid,
    input  logic              op_take,
    output lssc_pkg::op_t     op_out
);

    lssc_pkg::op_t dec;
    lssc_pkg::op_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_push;
    logic [5:0]    opc, fn;

    assign opc = instruction[31:26];
    assign fn  = instruction[5:0];

    always_comb
    begin
        dec              = '0;
        dec.kind         = lssc_pkg::K_BAD;
        dec.alu_op       = lssc_pkg::U_ADD;
        dec.target_store = target_store;
        dec.word_index   = word_index;
        dec.write_value  = write_value;
        dec.rs           = instruction[25:21];
        dec.rt           = instruction[20:16];
        dec.rd           = instruction[15:11];
        dec.simm         = {{16{instruction[15]}}, instruction[15:0]};
        dec.target       = instruction[25:0];
        unique case (action)
            lssc_pkg::ACT_EXEC:
            begin
                dec.is_exec = 1'b1;
                unique case (opc)
                    lssc_pkg::OP_RTYPE:
                    begin
                        dec.kind = lssc_pkg::K_ALU;
                        unique case (fn)
                            lssc_pkg::FN_ADD: dec.alu_op = lssc_pkg::U_ADD;
                            lssc_pkg::FN_SUB: dec.alu_op = lssc_pkg::U_SUB;
                            lssc_pkg::FN_AND: dec.alu_op = lssc_pkg::U_AND;
                            lssc_pkg::FN_OR:  dec.alu_op = lssc_pkg::U_OR;
                            default:          dec.kind   = lssc_pkg::K_BAD;
                        endcase
                    end
                    lssc_pkg::OP_LW:
                    begin
                        dec.kind    = lssc_pkg::K_MEM;
                        dec.is_load = 1'b1;
                    end
                    lssc_pkg::OP_SW:
                    begin
                        dec.kind     = lssc_pkg::K_MEM;
                        dec.is_store = 1'b1;
                    end
                    lssc_pkg::OP_BEQ:
                    begin
                        dec.kind   = lssc_pkg::K_PC;
                        dec.is_beq = 1'b1;
                    end
                    lssc_pkg::OP_J:
                    begin
                        dec.kind    = lssc_pkg::K_PC;
                        dec.is_jump = 1'b1;
                    end
                    default: dec.kind = lssc_pkg::K_BAD;
                endcase
            end
            lssc_pkg::ACT_WRITE:
            begin
                dec.kind     = lssc_pkg::K_MEM;
                dec.is_write = 1'b1;
            end
            lssc_pkg::ACT_READ:
            begin
                dec.kind    = lssc_pkg::K_MEM;
                dec.is_read = 1'b1;
            end
            default: dec.kind = lssc_pkg::K_BAD;
        endcase
    end

    assign full     = count_reg[1];
    assign do_push  = push && !full;
    assign op_valid = (count_reg != 2'd0);
    assign op_out   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ (op_take && op_valid);
        count_next  = count_reg + {1'b0, do_push} - {1'b0, op_take && op_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

### rtl/lssc_back.sv
// Back end: register file, data memory and program counter; executes queued items.
module lssc_back #(
    parameter int DATA_WORDS_LOG2 = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    output logic           op_take,
    input  lssc_pkg::op_t  op_in,
    output logic           empty,
    input  logic           pop,
    output logic [31:0]    read_value,
    output logic [31:0]    next_pc,
    output logic           status
);

    localparam int DATA_WORDS = 1 << DATA_WORDS_LOG2;

    // Two-step execution: register read, then execute and memory access.
    logic [31:0] regs_reg [1:31];
    logic [31:0] mem [DATA_WORDS];
    logic [31:0] pc_reg;
    logic        s1_reg;
    lssc_pkg::op_t op1_reg;
    logic [31:0] a_reg, b_reg, rv_reg;
    logic        s2_reg;
    logic        ld_reg;
    logic [4:0]  ld_rt_reg;
    logic        mem_rd_reg;
    logic [31:0] mem_q_reg;
    logic [31:0] pc_out_reg;
    logic        bad_reg;

    logic        out_busy;
    logic        can_exec;
    logic [31:0] a_rd, b_rd, alu, pc4, addr, pc_new;
    logic [DATA_WORDS_LOG2-1:0] midx;
    logic [4:0]  wreg;
    logic        wen;
    logic [31:0] wdat;

    function automatic logic [31:0] rf_read(input logic [4:0] i,
                                            input logic [31:0] r [1:31]);
        logic [31:0] v;
        v = (i == 5'd0) ? 32'd0 : r[i];
        return v;
    endfunction

    // Result register is free when empty or being popped this cycle.
    assign empty    = !s2_reg;
    assign out_busy = s2_reg && !pop;
    assign can_exec = s1_reg && !out_busy;
    // The load data is registered by the access, so the next item is read from the
    // register file in the cycle after it, when the load data can be forwarded.
    assign op_take  = op_valid && (!s1_reg || (can_exec && !op1_reg.is_load));

    // Load data enters the register file in the cycle after the access; forward it.
    always_comb
    begin
        a_rd = rf_read(op_in.rs, regs_reg);
        b_rd = rf_read(op_in.rt, regs_reg);
        if (ld_reg && ld_rt_reg != 5'd0 && ld_rt_reg == op_in.rs) a_rd = mem_q_reg;
        if (ld_reg && ld_rt_reg != 5'd0 && ld_rt_reg == op_in.rt) b_rd = mem_q_reg;
        if (wen && wreg != 5'd0 && wreg == op_in.rs) a_rd = wdat;
        if (wen && wreg != 5'd0 && wreg == op_in.rt) b_rd = wdat;
    end

    always_comb
    begin
        pc4  = pc_reg + lssc_pkg::PC_STEP;
        addr = a_reg + op1_reg.simm;
        midx = op1_reg.is_exec ? addr[DATA_WORDS_LOG2+1:2]
                               : DATA_WORDS_LOG2'(op1_reg.word_index);
        unique case (op1_reg.alu_op)
            lssc_pkg::U_ADD: alu = a_reg + b_reg;
            lssc_pkg::U_SUB: alu = a_reg - b_reg;
            lssc_pkg::U_AND: alu = a_reg & b_reg;
            lssc_pkg::U_OR:  alu = a_reg | b_reg;
            default:         alu = a_reg + b_reg;
        endcase
        pc_new = pc_reg;
        if (op1_reg.is_exec && op1_reg.kind != lssc_pkg::K_BAD)
        begin
            if (op1_reg.is_jump)
                pc_new = (pc4 & lssc_pkg::PC_HIGH_MASK)
                       | ({4'd0, op1_reg.target, 2'b00} & lssc_pkg::PC_LOW_MASK);
            else if (op1_reg.is_beq && a_reg == b_reg)
                pc_new = pc4 + {op1_reg.simm[29:0], 2'b00};
            else
                pc_new = pc4;
        end
        wen  = 1'b0;
        wreg = op1_reg.rd;
        wdat = alu;
        if (can_exec)
        begin
            if (op1_reg.kind == lssc_pkg::K_ALU && op1_reg.is_exec)
                wen = 1'b1;
            else if (op1_reg.is_write && op1_reg.target_store)
            begin
                wen  = 1'b1;
                wreg = op1_reg.word_index[4:0];
                wdat = op1_reg.write_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
            ld_reg <= 1'b0;
            pc_reg <= '0;
            for (int i = 1; i < 32; i++) regs_reg[i] <= '0;
        end
        else
        begin
            if (op_take) s1_reg <= 1'b1;
            else if (can_exec) s1_reg <= 1'b0;
            if (can_exec) s2_reg <= 1'b1;
            else if (pop) s2_reg <= 1'b0;
            ld_reg <= can_exec && op1_reg.is_load;
            if (can_exec) pc_reg <= pc_new;
            if (wen && wreg != 5'd0) regs_reg[wreg] <= wdat;
            if (ld_reg && ld_rt_reg != 5'd0) regs_reg[ld_rt_reg] <= mem_q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            op1_reg <= op_in;
            a_reg   <= a_rd;
            b_reg   <= b_rd;
        end
        if (can_exec)
        begin
            ld_rt_reg  <= op1_reg.rt;
            mem_rd_reg <= op1_reg.is_read && !op1_reg.target_store;
            rv_reg     <= (op1_reg.is_read && op1_reg.target_store)
                          ? rf_read(op1_reg.word_index[4:0], regs_reg) : 32'd0;
            pc_out_reg <= pc_new;
            bad_reg    <= (op1_reg.kind == lssc_pkg::K_BAD);
            if ((op1_reg.is_exec && op1_reg.is_store) || (op1_reg.is_write
                && !op1_reg.target_store))
                mem[midx] <= op1_reg.is_exec ? b_reg : op1_reg.write_value;
            mem_q_reg <= mem[midx];
        end
    end

    assign read_value = mem_rd_reg ? mem_q_reg : rv_reg;
    assign next_pc    = pc_out_reg;
    assign status     = bad_reg;

endmodule

### rtl/load_store_subset_cpu_step.sv
// Top level of the load/store subset CPU step block.
// Channel  | Signals                                                  | Transfer
// input    | push, full, action, instruction, target_store, ...       | push && !full
// result   | empty, pop, read_value, next_pc, status                  | pop && !empty
// A transfer enters a two-deep decode queue, then reads the register file into the
// execute registers and executes (ALU, branch, data memory port) from them.
// Sustained rate is one item per cycle while results are popped; the item after a load
// waits for the load data, which the data memory registers at the access.
// The single result register holds the back end while it is not popped.
// Reset clears the program counter, register file and queue; data memory is not cleared.
module load_store_subset_cpu_step #(
    parameter int DATA_WORDS_LOG2 = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [31:0] instruction,
    input  logic        target_store,
    input  logic [9:0]  word_index,
    input  logic [31:0] write_value,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] read_value,
    output logic [31:0] next_pc,
    output logic        status
);

    logic          op_valid;
    logic          op_take;
    lssc_pkg::op_t op;

    lssc_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .action(action),
        .instruction(instruction), .target_store(target_store),
        .word_index(word_index), .write_value(write_value),
        .op_valid(op_valid), .op_take(op_take), .op_out(op)
    );

    lssc_back #(.DATA_WORDS_LOG2(DATA_WORDS_LOG2)) u_back (
        .clk(clk), .rst_n(rst_n), .op_valid(op_valid), .op_take(op_take),
        .op_in(op), .empty(empty), .pop(pop), .read_value(read_value),
        .next_pc(next_pc), .status(status)
    );

endmodule

### rtl/lssc_checker.sv
// Port-level checker for the load/store subset CPU step block, with its bind.
module lssc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] next_pc,
    input logic        status
);

    // A waiting result holds its values until it is popped.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(next_pc) && $stable(status))
        else $error("result changed while stalled");

    // A result can only appear after a push.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $past(empty) && empty && !$past(push) && !$past(push, 2) && !$past(push, 3)
        && !$past(full) |=> empty)
        else $error("result without a push");

    // An unimplemented instruction leaves the program counter as the previous result showed.
    a_bad_pc: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop ##1 !empty && status |-> next_pc == $past(next_pc))
        else $error("program counter moved on a bad item");

    // Full only ever follows accepted pushes.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("queue filled without a push");

endmodule

bind load_store_subset_cpu_step lssc_checker u_lssc_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .empty(empty),
    .pop(pop), .next_pc(next_pc), .status(status)
);
